FILE: hdl/collatz_stopping_time_sweep_unit_assert.svh
// Assertion macros for the Collatz sweep unit.
`ifndef COLLATZ_STOPPING_TIME_SWEEP_UNIT_ASSERT_SVH
`define COLLATZ_STOPPING_TIME_SWEEP_UNIT_ASSERT_SVH

// Asserts that an antecedent implies a consequent on the same edge.
`define CST_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: implication failed");

// Asserts that an antecedent implies a consequent on the next edge.
`define CST_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: next-cycle implication failed");

`endif

FILE: hdl/cst_pkg.sv
package cst_pkg;
  localparam int START_BITS = 32;
  localparam int TRAJ_BITS  = 64;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 32;
  localparam int DIV_CNT_BITS = 6;
  localparam logic [2:0] MODE_ALL   = 3'd1;
  localparam logic [2:0] MODE_ODD   = 3'd2;
  localparam logic [2:0] MODE_EVEN  = 3'd3;
  localparam logic [2:0] MODE_POW2  = 3'd4;
  localparam logic [2:0] MODE_PRIME = 3'd5;
  localparam logic [2:0] MODE_MULT  = 3'd6;
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_BASE  = 2'd2;
  // 3n+1 stays in range while n <= (max-1)/3.
  localparam logic [TRAJ_BITS-1:0] TRAJ_SAFE = ({TRAJ_BITS{1'b1}} - 1) / 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV_START, ST_DIV_RUN, ST_DIV_EVAL, ST_TRAJ, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start a division
    logic div_prime;  // divisor is the trial divisor, else the base
    logic trial_next; // advance trial divisor by two
    logic traj_init;
    logic traj_step;
    logic finish;     // update record, fill output register
  } cst_cmd_t;

  typedef struct packed {
    logic pre_reject;  // zero, too large, or basic filter failed
    logic need_prime;
    logic need_mult;
    logic div_busy;
    logic rem_zero;
    logic trial_over;  // d > n/d, trial division finished
    logic traj_done;   // reached 1 or overflowed
  } cst_sts_t;
endpackage

FILE: hdl/cst_divider.sv
module cst_divider import cst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [START_BITS-1:0] dividend,
  input  logic [START_BITS-1:0] divisor,
  output logic                  busy,
  output logic [START_BITS-1:0] quotient,
  output logic [START_BITS-1:0] remainder
);
  // Restoring division, one quotient bit per cycle.
  logic [START_BITS-1:0] rem, quo, dsr;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [START_BITS:0] trial;

  assign trial = {rem, quo[START_BITS-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_BITS'(START_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[START_BITS]) begin
        rem <= trial[START_BITS-1:0];
        quo <= {quo[START_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[START_BITS-2:0], quo[START_BITS-1]};
        quo <= {quo[START_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule

FILE: hdl/cst_datapath.sv
module cst_datapath import cst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cst_cmd_t              cmd,
  output cst_sts_t              sts,
  input  logic [START_BITS-1:0] start_value,
  input  logic [2:0]            sweep_mode,
  input  logic [CFG_BITS-1:0]   upper_limit,
  input  logic [CFG_BITS-1:0]   multiple_base,
  output logic [START_BITS-1:0] value_out,
  output logic [COUNT_BITS-1:0] step_count,
  output logic                  overflow_flag,
  output logic [START_BITS-1:0] record_value,
  output logic [COUNT_BITS-1:0] record_count,
  output logic                  new_record
);
  logic [START_BITS-1:0] cand, trial_divisor;
  logic [TRAJ_BITS-1:0]  traj;
  logic [COUNT_BITS-1:0] steps;
  logic                  ovf;
  logic [START_BITS-1:0] record_start;
  logic [COUNT_BITS-1:0] record_steps;
  logic                  div_busy;
  logic [START_BITS-1:0] quo, rem;
  logic                  basic_ok;
  logic [COUNT_BITS-1:0] fin_count;
  logic                  fresh;

  cst_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(cand),
    .divisor(cmd.div_prime ? trial_divisor : multiple_base),
    .busy(div_busy), .quotient(quo), .remainder(rem)
  );

  always_comb begin
    unique case (sweep_mode)
      MODE_ALL:   basic_ok = 1'b1;
      MODE_ODD:   basic_ok = cand[0];
      MODE_EVEN:  basic_ok = !cand[0];
      MODE_POW2:  basic_ok = (cand & (cand - 1'b1)) == '0;
      MODE_PRIME: basic_ok = cand[0];
      MODE_MULT:  basic_ok = multiple_base != '0;
      default:    basic_ok = 1'b0;
    endcase
  end

  assign sts.pre_reject = (cand == '0) || (cand > upper_limit) || !basic_ok;
  assign sts.need_prime = sweep_mode == MODE_PRIME;
  assign sts.need_mult  = sweep_mode == MODE_MULT;
  assign sts.div_busy   = div_busy;
  assign sts.rem_zero   = rem == '0;
  assign sts.trial_over = trial_divisor > quo;
  assign sts.traj_done  = ovf || (traj == TRAJ_BITS'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand          <= start_value;
      trial_divisor <= START_BITS'(3);
    end else if (cmd.trial_next) begin
      trial_divisor <= trial_divisor + START_BITS'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      traj  <= '0;
      steps <= '0;
      ovf   <= 1'b0;
    end else if (cmd.traj_init) begin
      traj  <= TRAJ_BITS'(cand);
      steps <= '0;
      ovf   <= 1'b0;
    end else if (cmd.traj_step) begin
      if (!traj[0]) begin
        traj <= traj >> 1;
      end else if (traj > TRAJ_SAFE) begin
        ovf <= 1'b1;
      end else begin
        traj <= (traj << 1) + traj + TRAJ_BITS'(1);
      end
      if ((!traj[0] || traj <= TRAJ_SAFE) && steps != {COUNT_BITS{1'b1}}) begin
        steps <= steps + 1'b1;
      end
    end
  end

  assign fin_count = ovf ? '0 : steps;
  assign fresh     = !ovf && (steps > record_steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_start <= '0;
      record_steps <= '0;
    end else if (cmd.finish && fresh) begin
      record_start <= cand;
      record_steps <= steps;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      value_out     <= cand;
      step_count    <= fin_count;
      overflow_flag <= ovf;
      record_value  <= fresh ? cand : record_start;
      record_count  <= fresh ? steps : record_steps;
      new_record    <= fresh;
    end
  end
endmodule

FILE: hdl/cst_ctrl.sv
module cst_ctrl import cst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_fire,
  input  cst_sts_t sts,
  output cst_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid,
  output state_t   state
);
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire) state_next = ST_CHECK;
      ST_CHECK: begin
        priority if (sts.pre_reject) state_next = ST_IDLE;
        else if (sts.need_prime || sts.need_mult) state_next = ST_DIV_START;
        else state_next = ST_TRAJ;
      end
      ST_DIV_START: state_next = ST_DIV_RUN;
      ST_DIV_RUN:   if (!sts.div_busy) state_next = ST_DIV_EVAL;
      ST_DIV_EVAL: begin
        priority if (sts.need_mult) state_next = sts.rem_zero ? ST_TRAJ : ST_IDLE;
        else if (sts.trial_over) state_next = ST_TRAJ;
        else if (sts.rem_zero) state_next = ST_IDLE;
        else state_next = ST_DIV_START;
      end
      ST_TRAJ:  if (sts.traj_done) state_next = ST_DONE;
      ST_DONE:  state_next = ST_OUT;
      ST_OUT:   if (out_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      ST_CHECK: cmd.traj_init = 1'b1;
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        cmd.div_prime = sts.need_prime;
      end
      ST_DIV_EVAL: cmd.trial_next = sts.need_prime;
      ST_TRAJ: cmd.traj_step = !sts.traj_done;
      ST_DONE: cmd.finish = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

FILE: hdl/collatz_stopping_time_sweep_unit.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata[31:0] start_value
// m_axis   | out       | tdata[31:0] value_out, [47:32] step_count, [79:48] record_value,
//          |           |   [95:80] record_count; tuser[0] overflow_flag, [1] new_record
// cfg      | in        | cfg_index selects register, cfg_data value
// One item at a time. The filter check has its own state; mode 5 runs one serial division per odd
// trial divisor up to the square root, mode 6 a single division by the base. The trajectory
// then advances one Collatz step per cycle, and a done state fills the output register.
// Synchronous reset clears the state machine, record, trajectory and configuration registers to their reset values.
// A stalled result holds in the output register and the input stays not ready meanwhile.
`include "collatz_stopping_time_sweep_unit_assert.svh"
module collatz_stopping_time_sweep_unit import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // start_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // value_out, step_count, record_value, record_count
  output logic [1:0]  m_axis_tuser,   // overflow_flag, new_record
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [2:0]            sweep_mode;
  logic [CFG_BITS-1:0]   upper_limit, multiple_base;
  cst_cmd_t              cmd;
  cst_sts_t              sts;
  state_t                state;
  logic                  in_fire, out_fire;
  logic [START_BITS-1:0] value_out, record_value;
  logic [COUNT_BITS-1:0] step_count, record_count;
  logic                  overflow_flag, new_record;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_fire  = m_axis_tvalid && m_axis_tready;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_mode    <= MODE_ALL;
      upper_limit   <= CFG_BITS'(1000);
      multiple_base <= CFG_BITS'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  sweep_mode    <= cfg_data[2:0];
        REG_LIMIT: upper_limit   <= cfg_data;
        REG_BASE:  multiple_base <= cfg_data;
        default:   sweep_mode    <= sweep_mode;
      endcase
    end
  end

  cst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire), .sts(sts),
    .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .state(state)
  );

  cst_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .start_value(s_axis_tdata),
    .sweep_mode(sweep_mode), .upper_limit(upper_limit), .multiple_base(multiple_base),
    .value_out(value_out), .step_count(step_count), .overflow_flag(overflow_flag),
    .record_value(record_value), .record_count(record_count), .new_record(new_record)
  );

  assign m_axis_tdata = {record_count, record_value, step_count, value_out};
  assign m_axis_tuser = {new_record, overflow_flag};

  // A result never reports both overflow and a new record.
  `CST_ASSERT_IMP(a_ovf_no_rec, clk, rst, m_axis_tvalid, !(overflow_flag && new_record))
  // Input and output are never open together.
  `CST_ASSERT_IMP(a_excl, clk, rst, m_axis_tvalid, !s_axis_tready)
  // An accepted item always moves on to the filter check.
  `CST_ASSERT_NEXT(a_check, clk, rst, in_fire, state == ST_CHECK)
endmodule
